[hdl/cor_pkg.sv]
// Shared types and constants for the circle outline rasterizer.
// No dependencies; imported by circle_outline_rasterizer_top, outline_check_pkg and the bench.
`default_nettype none

package cor_pkg;

   // Coordinate, offset and error term widths
   localparam int unsigned COORD_BITS = 16;
   localparam int unsigned OFF_BITS   = COORD_BITS + 1;
   localparam int unsigned ERR_BITS   = COORD_BITS + 4;
   // Signed width that holds any unwrapped column or row
   localparam int unsigned POS_BITS   = COORD_BITS + 3;
   // Signed width that holds the error term plus or minus an offset
   localparam int unsigned CMP_BITS   = ERR_BITS + 2;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = COORD_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SURFACE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SURFACE_HEIGHT = 2'd1;

   localparam logic [COORD_BITS-1:0] SURFACE_WIDTH_RESET  = 16'd640;
   localparam logic [COORD_BITS-1:0] SURFACE_HEIGHT_RESET = 16'd480;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type               command;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
      logic [COORD_BITS-1:0] radius;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x_right;
      logic [COORD_BITS-1:0] x_left;
      logic [COORD_BITS-1:0] y_down;
      logic [COORD_BITS-1:0] y_up;
      logic [3:0]            visible_mask;
      logic                  last_step;
   } rsp_payload_type;

endpackage

`default_nettype wire

[hdl/circle_outline_rasterizer_top.sv]
// Midpoint circle outline walker: one mirrored point set per step request.
// Depends on cor_pkg for payload types, widths and register indexes.
//
// Usage
//   A request on the req_ channel carries a command. A start request latches
//   the centre and radius and primes the error term; it returns nothing and
//   abandons any circle in progress. Each step request while a circle is
//   active returns one response on the rsp_ channel: the four mirrored points
//   (centre +/- offsets, low 16 bits), a visibility mask clipped against the
//   surface size and a last_step flag. A step with no circle active is
//   dropped without a response.
//   Latency: a response is valid the cycle after its step request is taken.
//   Throughput: one request per cycle while req_stall is low; the whole step (point sums, clip
//   compares, error term update) sits between the state registers and the
//   response register, so nothing iterates.
//   Stall: req_stall rises only while a response is held and rsp_stall is
//   high; the response register holds its payload until it is taken.
//   Reset: synchronous; clears the walk (no circle active), drops any held
//   response and restores the surface size to 640 x 480.
//   The csr_ port writes surface_width (index 0) and surface_height
//   (index 1) at any edge with csr_write_en high; write only while idle.
`default_nettype none

module circle_outline_rasterizer_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire cor_pkg::req_payload_type             req_data,
   // Response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output cor_pkg::rsp_payload_type                  rsp_data,
   // Register write port
   input  wire logic                                 csr_write_en,
   input  wire logic [cor_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [cor_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import cor_pkg::*;

   // Surface size registers
   logic [COORD_BITS-1:0] surface_width_ff,  surface_width_in;
   logic [COORD_BITS-1:0] surface_height_ff, surface_height_in;

   // Walk state
   logic [COORD_BITS-1:0] cx_ff, cx_in;
   logic [COORD_BITS-1:0] cy_ff, cy_in;
   logic [OFF_BITS-1:0]   x_offset_ff, x_offset_in;
   logic [OFF_BITS-1:0]   y_offset_ff, y_offset_in;
   logic [ERR_BITS-1:0]   error_ff, error_in;
   logic                  active_ff, active_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic req_fire;
   logic step_fire;

   // Unwrapped point positions, signed
   logic signed [POS_BITS-1:0] x_right_pos, x_left_pos, y_down_pos, y_up_pos;
   logic                       xr_in, xl_in, yd_in, yu_in;

   // Error term decisions
   logic signed [CMP_BITS-1:0] err_wide;
   logic signed [CMP_BITS-1:0] err_plus_y;
   logic signed [CMP_BITS-1:0] err_minus_x;
   logic                       y_zero;
   logic                       go_horizontal;
   logic                       go_vertical;
   logic [ERR_BITS-1:0]        x_twice;
   logic [ERR_BITS-1:0]        y_twice;
   logic [ERR_BITS-1:0]        radius_twice;

   // Hold the request side only while a response waits and is not taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign step_fire = req_fire & (req_data.command == CMD_STEP) & active_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Mirrored points before wrapping
   always_comb begin
      x_right_pos = $signed({3'b000, cx_ff}) + $signed({2'b00, x_offset_ff});
      x_left_pos  = $signed({3'b000, cx_ff}) - $signed({2'b00, x_offset_ff});
      y_down_pos  = $signed({3'b000, cy_ff}) + $signed({2'b00, y_offset_ff});
      y_up_pos    = $signed({3'b000, cy_ff}) - $signed({2'b00, y_offset_ff});
   end

   // Clip each axis: non-negative and below the surface size
   always_comb begin
      xr_in = ~x_right_pos[POS_BITS-1]
              & (x_right_pos < $signed({3'b000, surface_width_ff}));
      xl_in = ~x_left_pos[POS_BITS-1]
              & (x_left_pos < $signed({3'b000, surface_width_ff}));
      yd_in = ~y_down_pos[POS_BITS-1]
              & (y_down_pos < $signed({3'b000, surface_height_ff}));
      yu_in = ~y_up_pos[POS_BITS-1]
              & (y_up_pos < $signed({3'b000, surface_height_ff}));
   end

   // Pick the move (y nonzero): horizontal when d < 0 and d + y <= 0, vertical when d > 0 and d - x > 0
   always_comb begin
      err_wide      = CMP_BITS'($signed(error_ff));
      err_plus_y    = err_wide + $signed({5'b00000, y_offset_ff});
      err_minus_x   = err_wide - $signed({5'b00000, x_offset_ff});
      y_zero        = (y_offset_ff == '0);
      go_horizontal = err_wide[CMP_BITS-1] & (err_plus_y <= 0) & ~y_zero;
      go_vertical   = ~err_wide[CMP_BITS-1] & (err_wide != 0)
                      & (err_minus_x > 0) & ~y_zero;
      x_twice       = {2'b00, x_offset_ff, 1'b0};
      y_twice       = {2'b00, y_offset_ff, 1'b0};
      radius_twice  = {3'b000, req_data.radius, 1'b0};
   end

   // Next state
   always_comb begin
      surface_width_in  = surface_width_ff;
      surface_height_in = surface_height_ff;
      cx_in             = cx_ff;
      cy_in             = cy_ff;
      x_offset_in       = x_offset_ff;
      y_offset_in       = y_offset_ff;
      error_in          = error_ff;
      active_in         = active_ff;
      rsp_valid_in      = rsp_valid_ff & rsp_stall;
      rsp_data_in       = rsp_data_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SURFACE_WIDTH:  surface_width_in  = csr_wdata;
            CSR_SURFACE_HEIGHT: surface_height_in = csr_wdata;
            default: ;
         endcase
      end

      if (req_fire && req_data.command == CMD_START) begin
         // Start at (0, r) with d = 1 - 2r
         cx_in       = req_data.center_x;
         cy_in       = req_data.center_y;
         x_offset_in = '0;
         y_offset_in = {1'b0, req_data.radius};
         error_in    = ERR_BITS'(1) - radius_twice;
         active_in   = 1'b1;
      end else if (step_fire) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.x_right       = x_right_pos[COORD_BITS-1:0];
         rsp_data_in.x_left        = x_left_pos[COORD_BITS-1:0];
         rsp_data_in.y_down        = y_down_pos[COORD_BITS-1:0];
         rsp_data_in.y_up          = y_up_pos[COORD_BITS-1:0];
         rsp_data_in.visible_mask  = {xl_in & yu_in, xr_in & yu_in,
                                      xl_in & yd_in, xr_in & yd_in};
         rsp_data_in.last_step     = y_zero;

         if (go_horizontal) begin
            // x += 1, d += 2x + 3 (old x)
            x_offset_in = x_offset_ff + OFF_BITS'(1);
            error_in    = error_ff + x_twice + ERR_BITS'(3);
         end else if (go_vertical) begin
            // y -= 1, d += 3 - 2y (old y)
            y_offset_in = y_offset_ff - OFF_BITS'(1);
            error_in    = error_ff + ERR_BITS'(3) - y_twice;
         end else begin
            // Diagonal: d += 2(x + 1 - y) with old offsets
            x_offset_in = x_offset_ff + OFF_BITS'(1);
            error_in    = error_ff + x_twice + ERR_BITS'(2) - y_twice;
            if (y_zero) begin
               active_in = 1'b0;
            end else begin
               y_offset_in = y_offset_ff - OFF_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         surface_width_ff  <= SURFACE_WIDTH_RESET;
         surface_height_ff <= SURFACE_HEIGHT_RESET;
         cx_ff             <= '0;
         cy_ff             <= '0;
         x_offset_ff       <= '0;
         y_offset_ff       <= '0;
         error_ff          <= '0;
         active_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         surface_width_ff  <= surface_width_in;
         surface_height_ff <= surface_height_in;
         cx_ff             <= cx_in;
         cy_ff             <= cy_in;
         x_offset_ff       <= x_offset_in;
         y_offset_ff       <= y_offset_in;
         error_ff          <= error_in;
         active_ff         <= active_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // A step on an active circle always yields a response next cycle
   a_step_responds: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> rsp_valid)
      else $error("step request on active circle gave no response");

   // A start request never yields a response
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.command == CMD_START) |=> !rsp_valid)
      else $error("start request produced a response");

   // The step taken at zero vertical offset ends the circle
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (step_fire && y_offset_ff == '0) |=> (!active_ff && rsp_data.last_step))
      else $error("last step did not end the circle");

   // Requests are held back only while a response is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stall without a held response");

endmodule

`default_nettype wire

[sim/outline_check_pkg.sv]
`timescale 1ns / 1ps
// Expected-point tracker for the circle outline rasterizer bench: mirrors the
// midpoint walk and compares returned point sets. Depends on cor_pkg.
package outline_check_pkg;
   import cor_pkg::*;

   class outline_point_checker;
      logic [COORD_BITS-1:0]      surf_w;
      logic [COORD_BITS-1:0]      surf_h;
      logic [COORD_BITS-1:0]      centre_col;
      logic [COORD_BITS-1:0]      centre_row;
      logic [OFF_BITS-1:0]        x_off;
      logic [OFF_BITS-1:0]        y_off;
      logic signed [ERR_BITS-1:0] walk_err;
      bit                         in_circle;
      rsp_payload_type            pending_points[$];
      int unsigned                failures;

      function new();
         surf_w     = SURFACE_WIDTH_RESET;
         surf_h     = SURFACE_HEIGHT_RESET;
         centre_col = '0;
         centre_row = '0;
         x_off      = '0;
         y_off      = '0;
         walk_err   = '0;
         in_circle  = 1'b0;
         failures   = 0;
      endfunction

      function void note_register(logic [CSR_INDEX_BITS-1:0] index,
                                  logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_SURFACE_WIDTH: begin
               surf_w = value;
            end
            CSR_SURFACE_HEIGHT: begin
               surf_h = value;
            end
            default: begin
            end
         endcase
      endfunction

      function bit on_surface(longint col, longint row);
         return col >= 0 && row >= 0 && col < longint'(surf_w) && row < longint'(surf_h);
      endfunction

      // Take one accepted request: a start primes the walk, a step queues
      // the point set it must return and moves the walk on.
      function void note_request(req_payload_type item);
         longint          xm;
         longint          ym;
         longint          d;
         longint          xr;
         longint          xl;
         longint          yd;
         longint          yu;
         rsp_payload_type pt;
         if (item.command == CMD_START) begin
            centre_col = item.center_x;
            centre_row = item.center_y;
            x_off      = '0;
            y_off      = {1'b0, item.radius};
            d          = 1 - 2 * longint'(item.radius);
            walk_err   = d[ERR_BITS-1:0];
            in_circle  = 1'b1;
            return;
         end
         if (!in_circle)
            return;
         xm = longint'(x_off);
         ym = longint'(y_off);
         d  = longint'(walk_err);
         xr = longint'(centre_col) + xm;
         xl = longint'(centre_col) - xm;
         yd = longint'(centre_row) + ym;
         yu = longint'(centre_row) - ym;
         pt.x_right      = xr[COORD_BITS-1:0];
         pt.x_left       = xl[COORD_BITS-1:0];
         pt.y_down       = yd[COORD_BITS-1:0];
         pt.y_up         = yu[COORD_BITS-1:0];
         pt.visible_mask = {on_surface(xl, yu), on_surface(xr, yu),
                            on_surface(xl, yd), on_surface(xr, yd)};
         pt.last_step    = (ym == 0);
         pending_points.push_back(pt);
         if (d < 0 && 2 * (d + ym) - 1 <= 0 && ym != 0) begin
            xm = xm + 1;
            d  = d + 2 * xm + 1;
         end else if (d > 0 && 2 * (d - xm) - 1 > 0 && ym != 0) begin
            ym = ym - 1;
            d  = d + 1 - 2 * ym;
         end else begin
            xm = xm + 1;
            d  = d + 2 * (xm - ym);
            if (ym == 0)
               in_circle = 1'b0;
            else
               ym = ym - 1;
         end
         x_off    = xm[OFF_BITS-1:0];
         y_off    = ym[OFF_BITS-1:0];
         walk_err = d[ERR_BITS-1:0];
      endfunction

      function bit walking();
         return in_circle;
      endfunction

      function int pending();
         return pending_points.size();
      endfunction

      function void check_points(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_points.size() == 0) begin
            $error("response with none outstanding: %h", got);
            failures++;
            return;
         end
         want = pending_points.pop_front();
         if (got.x_right !== want.x_right) begin
            $error("x_right: expected %0d, got %0d", want.x_right, got.x_right);
            failures++;
         end
         if (got.x_left !== want.x_left) begin
            $error("x_left: expected %0d, got %0d", want.x_left, got.x_left);
            failures++;
         end
         if (got.y_down !== want.y_down) begin
            $error("y_down: expected %0d, got %0d", want.y_down, got.y_down);
            failures++;
         end
         if (got.y_up !== want.y_up) begin
            $error("y_up: expected %0d, got %0d", want.y_up, got.y_up);
            failures++;
         end
         if (got.visible_mask !== want.visible_mask) begin
            $error("visible_mask: expected %b, got %b", want.visible_mask, got.visible_mask);
            failures++;
         end
         if (got.last_step !== want.last_step) begin
            $error("last_step: expected %b, got %b", want.last_step, got.last_step);
            failures++;
         end
      endfunction

      function void drop_leftovers();
         if (pending_points.size() != 0) begin
            $error("%0d expected responses never arrived", pending_points.size());
            failures += pending_points.size();
            pending_points.delete();
         end
      endfunction
   endclass

endpackage

[sim/circle_outline_rasterizer_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for circle_outline_rasterizer_top: directed and random
// circle walks under several surface sizes. Depends on cor_pkg, outline_check_pkg.
module circle_outline_rasterizer_top_tb;
   import cor_pkg::*;
   import outline_check_pkg::*;

   localparam int HOLD_OFF_CYCLES = 120;   // long receiver stall to fill the block
   localparam int SETTLE_CYCLES   = 4;     // quiet cycles after the last response
   localparam int DRAIN_LIMIT     = 2000;  // cycles to wait for outstanding responses

   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   req_payload_type               req_data     = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   rsp_payload_type               rsp_data;
   logic                          csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index    = CSR_SURFACE_WIDTH;
   logic [CSR_DATA_BITS-1:0]      csr_wdata    = '0;

   // Shared between the request driver and the response-side staller
   bit                            no_idle      = 1'b0;
   bit                            hold_off_req = 1'b0;

   outline_point_checker          points;

   circle_outline_rasterizer_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #3_000_000;
      $display("circle_outline_rasterizer_top_tb failed");
      $finish;
   end

   // Response side: stall at random, hold off for a long stretch on request,
   // and never stall while the no-idle stretch runs.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < 21);
      end
   end

   // Compare every response taken; values seen here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         points.check_points(rsp_data);
   end

   function automatic req_payload_type make_request(cmd_type cmd, int cx, int cy, int r);
      req_payload_type item;
      item.command  = cmd;
      item.center_x = cx[COORD_BITS-1:0];
      item.center_y = cy[COORD_BITS-1:0];
      item.radius   = r[COORD_BITS-1:0];
      return item;
   endfunction

   // Step request with junk in the unused fields
   function automatic req_payload_type random_step();
      return make_request(CMD_STEP, $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
   endfunction

   // Centre coordinate: anywhere, up to just past the surface edge, near zero or near the top
   function automatic int pick_coord(int limit);
      int top;
      top = limit + 32;
      if (top > 65535)
         top = 65535;
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 65535);
         1: return $urandom_range(0, top);
         2: return 65535 - $urandom_range(0, 40);
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   // Offer one request, idling first at random; hold it until taken.
   // req_valid stays high afterwards so back-to-back requests need no toggle.
   task automatic send_request(input req_payload_type item);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 21) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (req_stall);
      points.note_request(item);
   endtask

   // Drop valid and wait for every outstanding response, up to DRAIN_LIMIT, then idle for SETTLE_CYCLES
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (points.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      points.drop_leftovers();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both surface registers on consecutive edges; call only when idle
   task automatic set_surface(input int w, input int h);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SURFACE_WIDTH;
      csr_wdata    <= w[CSR_DATA_BITS-1:0];
      @(posedge clock);
      points.note_register(CSR_SURFACE_WIDTH, w[CSR_DATA_BITS-1:0]);
      csr_index    <= CSR_SURFACE_HEIGHT;
      csr_wdata    <= h[CSR_DATA_BITS-1:0];
      @(posedge clock);
      points.note_register(CSR_SURFACE_HEIGHT, h[CSR_DATA_BITS-1:0]);
      csr_write_en <= 1'b0;
   endtask

   // Mostly whole circles with random content; some walks are cut short by a
   // fresh start, some steps arrive with no circle active.
   task automatic run_circles(input int goal, input int w, input int h);
      int  counted;
      int  steps;
      int  walk_cap;
      int  roll;
      int  r;
      bit  huge;
      counted = 0;
      while (counted < goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            if (points.walking())
               counted++;
            send_request(random_step());
            continue;
         end
         huge = ($urandom_range(0, 9) == 0);
         r    = huge ? $urandom_range(0, 65535) : $urandom_range(0, 24);
         send_request(make_request(CMD_START, pick_coord(w), pick_coord(h), r));
         counted++;
         if (huge)
            walk_cap = $urandom_range(1, 40);
         else if (roll < 18)
            walk_cap = $urandom_range(0, r);     // broken walk, abandoned early
         else
            walk_cap = 1_000_000;
         steps = 0;
         while (points.walking() && steps < walk_cap) begin
            send_request(random_step());
            counted++;
            steps++;
         end
         // Occasionally step past the end of the circle
         if ($urandom_range(0, 3) == 0)
            send_request(random_step());
      end
   endtask

   initial begin
      int phase;
      int w;
      int h;
      points = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset surface size of 640 x 480
      send_request(make_request(CMD_STEP, 65535, 65535, 65535));   // no circle: dropped
      send_request(make_request(CMD_START, 100, 100, 0));          // zero radius
      send_request(make_request(CMD_STEP, 0, 0, 0));
      send_request(make_request(CMD_STEP, 0, 0, 0));               // circle over
      send_request(make_request(CMD_START, 0, 0, 3));              // negative points wrap
      repeat (7) send_request(make_request(CMD_STEP, 0, 0, 0));
      send_request(make_request(CMD_START, 65535, 65535, 65535));  // all extremes
      send_request(make_request(CMD_STEP, 65535, 65535, 65535));
      send_request(make_request(CMD_STEP, 0, 0, 0));
      send_request(make_request(CMD_START, 639, 479, 1));          // on the clip edges
      send_request(make_request(CMD_STEP, 0, 0, 0));
      send_request(make_request(CMD_START, 320, 240, 2));          // abandons the last one
      repeat (5) send_request(make_request(CMD_STEP, 0, 0, 0));
      settle();

      // Random part over several surface sizes
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin w = 0;     h = 0;     end
            1: begin w = 65535; h = 65535; end
            2: begin w = 1;     h = 1;     end
            3: begin w = 320;   h = 200;   end
            default: begin
               w = $urandom_range(0, 65535);
               h = $urandom_range(0, 65535);
            end
         endcase
         set_surface(w, h);
         no_idle = (phase == 1);        // one stretch with no idling either side
         if (phase == 2)
            hold_off_req = 1'b1;        // fill the block while requests keep coming
         run_circles(63, w, h);
         settle();
      end
      no_idle = 1'b0;

      if (points.failures == 0)
         $display("circle_outline_rasterizer_top_tb passed");
      else
         $display("circle_outline_rasterizer_top_tb failed");
      $finish;
   end

endmodule
